// ----- rtl/core/bsp_pkg.sv -----
// Shared types, constants and helpers of the sliding B-spline path evaluator.
`default_nettype none
package bsp_pkg;

    // Fraction bits of the segment parameter t.
    localparam int PFB = 16;
    localparam logic [PFB:0] ONE_T = {1'b1, {PFB{1'b0}}};
    localparam logic [15:0] T_STEP_RESET = 16'd328;

    localparam int WGT_W = 24;
    localparam int ACC_W = 56;
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;
    localparam int FIFO_DEPTH = 4;

    localparam int STEP_SHL = (PFB >= 16) ? PFB - 16 : 0;
    localparam int STEP_SHR = (PFB >= 16) ? 0 : 16 - PFB;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_WGT, S_MAC,
        S_PXG, S_PXW, S_PZG, S_PZW, S_NRM, S_SQ0, S_SQ1, S_SQ2,
        S_SQRT, S_TXG, S_TXW, S_TZG, S_TZW, S_FIN
    } back_state_t;

    // Moves the Q0.16 step onto the parameter grid.
    function automatic logic [PFB:0] step_conv(input logic [15:0] s);
        logic [PFB+15:0] w;
        w = {{PFB{1'b0}}, s};
        w = (w << STEP_SHL) >> STEP_SHR;
        return w[PFB:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bsp_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module bsp_div
    import bsp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_NW-1:0] num,
    input  wire logic [DIV_DW-1:0] den,
    output logic [DIV_NW-1:0]      quo,
    output div_status_t            status
);

    logic [$clog2(DIV_NW)-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [DIV_DW-1:0]         rem_reg;
    logic [DIV_NW-1:0]         quo_reg;
    logic [DIV_DW-1:0]         den_reg;
    logic [DIV_DW:0]           rem_sh;
    logic                      fits;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[DIV_NW-1]};
        fits   = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(DIV_NW))'(DIV_NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DIV_DW'(rem_sh - {1'b0, den_reg});
            end else begin
                rem_reg <= DIV_DW'(rem_sh);
            end
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign quo         = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

// ----- rtl/core/bsp_front.sv -----
// Input stage: takes beats from the stream and classifies them into items.
`default_nettype none
module bsp_front
    import bsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // point_x, point_y
    input  wire logic        s_axis_tuser,  // cmd
    output logic             out_valid,
    input  wire logic        out_ready,
    output item_t            out_item
);

    logic  vld_reg;
    item_t item_reg;

    assign s_axis_tready = !vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            item_reg.cmd <= s_axis_tuser ? CMD_TICK : CMD_PUSH;
            item_reg.px  <= s_axis_tdata[31:0];
            item_reg.py  <= s_axis_tdata[63:32];
        end
    end

    assign out_valid = vld_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

// ----- rtl/core/bsp_fifo.sv -----
// Short item queue between the input stage and the evaluator.
`default_nettype none
module bsp_fifo
    import bsp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output item_t      out_item
);

    localparam int PW = $clog2(FIFO_DEPTH);

    item_t          mem [FIFO_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;
    logic           do_wr;
    logic           do_rd;

    assign in_ready  = count_reg != (PW+1)'(FIFO_DEPTH);
    assign out_valid = count_reg != '0;
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_wr && do_rd) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bsp_back.sv -----
// Evaluator: sequencer around one shared multiplier, the divider and a square root step.
`default_nettype none
module bsp_back
    import bsp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [15:0]  t_step,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire item_t        in_item,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,
    output logic              m_axis_tuser
);

    // 2^16 = 3 * THIRD_2P16 + 1, and RECIP3 = (2^21 + 1) / 3 divides exactly below 2^21.
    localparam logic [15:0] THIRD_2P16 = 16'd21845;
    localparam logic [19:0] RECIP3     = 20'd699051;

    back_state_t state_reg, state_next;

    logic [PFB-1:0]           t_reg;
    logic signed [31:0]       win_reg [8];
    item_t                    cur_reg;
    logic [PFB:0]             t2_reg, u2_reg, t3_reg, u3_reg;
    logic signed [WGT_W-1:0]  w_reg  [4];
    logic signed [WGT_W-1:0]  dw_reg [4];
    logic [5:0]               cnt_reg;
    logic signed [ACC_W-1:0]  sx_reg, sy_reg, vx_reg, vy_reg;
    logic signed [63:0]       prod_reg;
    logic [ACC_W-1:0]         ax_reg, ay_reg;
    logic                     nx_reg, ny_reg;
    logic [61:0]              sq_reg, rad_reg;
    logic [32:0]              srem_reg;
    logic [30:0]              root_reg;
    logic signed [15:0]       tx_reg, tz_reg;
    logic [31:0]              posx_reg;
    logic [31:0]              posz_reg;
    logic [35:0]              h_reg;
    logic [35:0]              q_reg;
    logic                     m_valid_reg;
    logic [127:0]             m_data_reg;
    logic                     m_user_reg;

    logic [PFB:0]             t_ext, u_ext, t_sum;
    logic signed [31:0]       mul_a, mul_b;
    logic [1:0]               mac_i, mac_s, acc_sel;
    logic                     out_free;
    logic                     div_start;
    logic [DIV_NW-1:0]        div_num;
    logic [DIV_DW-1:0]        div_den;
    logic [DIV_NW-1:0]        div_quo;
    div_status_t              div_st;
    logic [ACC_W-1:0]         max_mag;
    logic [34:0]              sq_sh, sq_trial;
    logic signed [WGT_W-1:0]  ws_t, ws_t2, ws_t3, ws_u2, ws_u3, ws_one;
    logic                     wrap;

    function automatic logic [PFB:0] rnd(input logic signed [63:0] p);
        logic [63:0] q;
        q = unsigned'(p) + (64'd1 << (PFB - 1));
        return (PFB+1)'(q >> PFB);
    endfunction

    function automatic logic signed [WGT_W-1:0] sw(input logic [PFB:0] v);
        return WGT_W'(signed'({1'b0, v}));
    endfunction

    // Rounded magnitude over 2^(PFB+1); the remaining division is by three.
    function automatic logic [35:0] half_num(input logic signed [ACC_W-1:0] s);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] sum;
        mag = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
        sum = mag + (ACC_W'(3) << PFB);
        return 36'(sum >> (PFB + 1));
    endfunction

    // Folding the upper half onto the lower keeps the reciprocal product narrow.
    function automatic logic [35:0] div3(input logic [35:0] h);
        logic [19:0] hi;
        logic [20:0] fold;
        logic [40:0] prod;
        hi   = h[35:16];
        fold = 21'(hi) + 21'(h[15:0]);
        prod = 41'(fold) * 41'(RECIP3);
        return 36'(hi) * 36'(THIRD_2P16) + 36'(prod >> 21);
    endfunction

    function automatic logic [31:0] pos_sat(input logic [35:0] q, input logic neg);
        logic [31:0] r;
        if (!neg && q > 36'h7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (neg && q > 36'h8000_0000) begin
            r = 32'h8000_0000;
        end else if (neg) begin
            r = 32'(-q[31:0]);
        end else begin
            r = q[31:0];
        end
        return r;
    endfunction

    bsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .status  (div_st)
    );

    assign t_ext  = {1'b0, t_reg};
    assign u_ext  = ONE_T - t_ext;
    assign t_sum  = t_ext + step_conv(t_step);
    assign wrap   = t_sum >= ONE_T;
    assign mac_i  = cnt_reg[3:2];
    assign mac_s  = cnt_reg[1:0];
    assign acc_sel = 2'(cnt_reg[1:0] - 2'd1);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign max_mag = (ax_reg > ay_reg) ? ax_reg : ay_reg;
    assign sq_sh    = {srem_reg, rad_reg[61:60]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    assign ws_t   = sw(t_ext);
    assign ws_t2  = sw(t2_reg);
    assign ws_t3  = sw(t3_reg);
    assign ws_u2  = sw(u2_reg);
    assign ws_u3  = sw(u3_reg);
    assign ws_one = sw(ONE_T);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M0: begin
                mul_a = 32'(t_ext);
                mul_b = 32'(t_ext);
            end
            S_M1: begin
                mul_a = 32'(u_ext);
                mul_b = 32'(u_ext);
            end
            S_M2: begin
                mul_a = 32'(t2_reg);
                mul_b = 32'(t_ext);
            end
            S_M3: begin
                mul_a = 32'(u2_reg);
                mul_b = 32'(u_ext);
            end
            S_MAC: begin
                mul_a = mac_s[1] ? 32'(dw_reg[mac_i]) : 32'(w_reg[mac_i]);
                mul_b = win_reg[{mac_i, mac_s[0]}];
            end
            S_SQ0: begin
                mul_a = 32'(ax_reg[30:0]);
                mul_b = 32'(ax_reg[30:0]);
            end
            S_SQ1: begin
                mul_a = 32'(ay_reg[30:0]);
                mul_b = 32'(ay_reg[30:0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid && in_item.cmd == CMD_TICK) begin
                    state_next = S_M0;
                end
            end
            S_M0:  state_next = S_M1;
            S_M1:  state_next = S_M2;
            S_M2:  state_next = S_M3;
            S_M3:  state_next = S_M4;
            S_M4:  state_next = S_WGT;
            S_WGT: state_next = S_MAC;
            S_MAC: begin
                if (cnt_reg == 6'd16) begin
                    state_next = S_PXG;
                end
            end
            S_PXG: state_next = S_PXW;
            S_PXW: state_next = S_PZG;
            S_PZG: state_next = S_PZW;
            S_PZW: state_next = S_NRM;
            S_NRM: begin
                if (ax_reg == '0 && ay_reg == '0) begin
                    state_next = S_FIN;
                end else if (max_mag[ACC_W-1:30] == '0 && max_mag[29]) begin
                    state_next = S_SQ0;
                end
            end
            S_SQ0: state_next = S_SQ1;
            S_SQ1: state_next = S_SQ2;
            S_SQ2: state_next = S_SQRT;
            S_SQRT: begin
                if (cnt_reg == 6'd30) begin
                    state_next = S_TXG;
                end
            end
            S_TXG: begin
                div_start  = 1'b1;
                div_num    = DIV_NW'({ax_reg[29:0], 14'd0}) + DIV_NW'(root_reg >> 1);
                div_den    = DIV_DW'(root_reg);
                state_next = S_TXW;
            end
            S_TXW: begin
                if (div_st.done) begin
                    state_next = S_TZG;
                end
            end
            S_TZG: begin
                div_start  = 1'b1;
                div_num    = DIV_NW'({ay_reg[29:0], 14'd0}) + DIV_NW'(root_reg >> 1);
                div_den    = DIV_DW'(root_reg);
                state_next = S_TZW;
            end
            S_TZW: begin
                if (div_st.done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control window and segment parameter; reset clears them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_reg <= '0;
            for (int i = 0; i < 8; i++) begin
                win_reg[i] <= '0;
            end
        end else if (state_reg == S_IDLE && in_valid && in_item.cmd == CMD_PUSH) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= win_reg[i+2];
            end
            win_reg[6] <= in_item.px;
            win_reg[7] <= in_item.py;
        end else if (state_reg == S_FIN && out_free) begin
            if (wrap) begin
                t_reg <= PFB'(t_sum - ONE_T);
                for (int i = 0; i < 6; i++) begin
                    win_reg[i] <= win_reg[i+2];
                end
                win_reg[6] <= cur_reg.px;
                win_reg[7] <= cur_reg.py;
            end else begin
                t_reg <= PFB'(t_sum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE: begin
                cur_reg <= in_item;
            end
            S_M1: t2_reg <= rnd(prod_reg);
            S_M2: u2_reg <= rnd(prod_reg);
            S_M3: t3_reg <= rnd(prod_reg);
            S_M4: u3_reg <= rnd(prod_reg);
            S_WGT: begin
                w_reg[0]  <= ws_u3;
                w_reg[1]  <= WGT_W'(3 * ws_t3 - 6 * ws_t2 + 4 * ws_one);
                w_reg[2]  <= WGT_W'(-3 * ws_t3 + 3 * ws_t2 + 3 * ws_t + ws_one);
                w_reg[3]  <= ws_t3;
                dw_reg[0] <= WGT_W'(-3 * ws_u2);
                dw_reg[1] <= WGT_W'(9 * ws_t2 - 12 * ws_t);
                dw_reg[2] <= WGT_W'(-9 * ws_t2 + 6 * ws_t + 3 * ws_one);
                dw_reg[3] <= WGT_W'(3 * ws_t2);
                sx_reg    <= '0;
                sy_reg    <= '0;
                vx_reg    <= '0;
                vy_reg    <= '0;
                cnt_reg   <= '0;
            end
            S_MAC: begin
                cnt_reg <= cnt_reg + 6'd1;
                // The product issued in the previous cycle lands here.
                if (cnt_reg != '0) begin
                    case (acc_sel)
                        2'd0:    sx_reg <= sx_reg + ACC_W'(prod_reg);
                        2'd1:    sy_reg <= sy_reg + ACC_W'(prod_reg);
                        2'd2:    vx_reg <= vx_reg + ACC_W'(prod_reg);
                        default: vy_reg <= vy_reg + ACC_W'(prod_reg);
                    endcase
                end
            end
            S_PXG: h_reg <= half_num(sx_reg);
            S_PXW: q_reg <= div3(h_reg);
            S_PZG: begin
                posx_reg <= pos_sat(q_reg, sx_reg[ACC_W-1]);
                h_reg    <= half_num(sy_reg);
            end
            S_PZW: begin
                q_reg  <= div3(h_reg);
                nx_reg <= vx_reg[ACC_W-1];
                ny_reg <= vy_reg[ACC_W-1];
                ax_reg <= vx_reg[ACC_W-1] ? ACC_W'(-vx_reg) : ACC_W'(vx_reg);
                ay_reg <= vy_reg[ACC_W-1] ? ACC_W'(-vy_reg) : ACC_W'(vy_reg);
                tx_reg <= '0;
                tz_reg <= '0;
            end
            S_NRM: begin
                posz_reg <= pos_sat(q_reg, sy_reg[ACC_W-1]);
                if (max_mag[ACC_W-1:30] != '0) begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                end else if (!max_mag[29]) begin
                    ax_reg <= ax_reg << 1;
                    ay_reg <= ay_reg << 1;
                end
            end
            S_SQ1: sq_reg <= prod_reg[61:0];
            S_SQ2: begin
                rad_reg  <= sq_reg + prod_reg[61:0];
                srem_reg <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            S_SQRT: begin
                cnt_reg <= cnt_reg + 6'd1;
                rad_reg <= rad_reg << 2;
                if (sq_sh >= sq_trial) begin
                    srem_reg <= 33'(sq_sh - sq_trial);
                    root_reg <= {root_reg[29:0], 1'b1};
                end else begin
                    srem_reg <= 33'(sq_sh);
                    root_reg <= {root_reg[29:0], 1'b0};
                end
            end
            S_TXW: begin
                if (div_st.done) begin
                    tx_reg <= nx_reg ? 16'(-div_quo[15:0]) : div_quo[15:0];
                end
            end
            S_TZW: begin
                if (div_st.done) begin
                    tz_reg <= ny_reg ? 16'(-div_quo[15:0]) : div_quo[15:0];
                end
            end
            S_FIN: begin
                if (out_free) begin
                    m_data_reg[31:0]    <= posx_reg;
                    m_data_reg[63:32]   <= posz_reg;
                    m_data_reg[79:64]   <= tx_reg;
                    m_data_reg[95:80]   <= tz_reg;
                    m_data_reg[111:96]  <= tz_reg;
                    m_data_reg[127:112] <= 16'(-tx_reg);
                    m_user_reg          <= wrap;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_idle_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_st.busy)
        else $error("divider busy while the sequencer is idle");

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == S_TXW || state_reg == S_TZW))
        else $error("quotient arrived with no state waiting for it");

    a_fin_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && out_free) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("finished tick did not reach the output register");

endmodule
`default_nettype wire

// ----- rtl/core/sliding_bspline_path_eval.sv -----
// Top level of the sliding uniform cubic B-spline path evaluator.
// A push beat (tuser low) shifts a control point into the four-point window
// and is taken while the evaluator stays idle. A tick beat (tuser high) runs
// the multiply-accumulate pass on the single 32x32 multiplier, the two
// position roundings by a reciprocal of three, the normalising shift (one bit
// per step, at most 29 bits), the 31-step square root and the shared 48-bit
// divider, used twice for the tangent components; a zero derivative skips
// the square root and the divisions. A four-entry queue lets the input side
// keep taking beats while a tick is evaluated, and the result register lets
// the next item start while a result waits.
`default_nettype none
module sliding_bspline_path_eval
    import bsp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,  // point_x [31:0], point_y [63:32]
    input  wire logic         s_axis_tuser,  // cmd
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x, pos_z, tangent_x, tangent_z, bitangent_x, bitangent_z
    output logic [127:0]      m_axis_tdata,
    output logic              m_axis_tuser,  // segment_wrapped
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);

    logic [15:0] t_step_reg;
    logic        fr_valid, fr_ready;
    item_t       fr_item;
    logic        q_valid, q_ready;
    item_t       q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_step_reg <= T_STEP_RESET;
        end else if (cfg_valid) begin
            t_step_reg <= cfg_data;
        end
    end

    bsp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_item      (fr_item)
    );

    bsp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    bsp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .t_step        (t_step_reg),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_item       (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire
